/* hw/rtl/mpcrc_pkg.sv */
// ----------------------------------------------------------------------------
// mpcrc_pkg
// Shared constants and serial-step functions for the multi-polynomial crc
// word update block.
// ----------------------------------------------------------------------------
package mpcrc_pkg;

    localparam int MAX_WORD_BITS = 32;
    localparam int WORD_BITS_W   = 6;
    localparam int CRC_W         = 16;
    localparam int SEL_W         = 3;
    localparam int CFG_IDX_W     = 2;

    typedef logic [CRC_W-1:0]         t_crc;
    typedef logic [SEL_W-1:0]         t_sel;
    typedef logic [WORD_BITS_W-1:0]   t_word_bits;
    typedef logic [MAX_WORD_BITS-1:0] t_data;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    localparam t_sel POLY_CRC5  = 3'd0;
    localparam t_sel POLY_CRC8  = 3'd1;
    localparam t_sel POLY_C16_A = 3'd2;
    localparam t_sel POLY_C16_B = 3'd3;
    localparam t_sel POLY_C16_C = 3'd4;

    localparam t_cfg_idx CFG_POLY_SELECT = 2'd0;
    localparam t_cfg_idx CFG_WORD_BITS   = 2'd1;
    localparam t_cfg_idx CFG_SEED        = 2'd2;

    localparam t_sel       POLY_RESET      = POLY_C16_A;
    localparam t_word_bits WORD_BITS_RESET = 6'd8;
    localparam t_word_bits WORD_BITS_MAX   = WORD_BITS_W'(MAX_WORD_BITS);

    function automatic t_crc width_mask(input t_sel sel);
        t_crc mask;
        case (sel)
            POLY_CRC5: mask = 16'h001F;
            POLY_CRC8: mask = 16'h00FF;
            default:   mask = 16'hFFFF;
        endcase
        return mask;
    endfunction

    function automatic logic sel_known(input t_sel sel);
        return sel <= POLY_C16_C;
    endfunction

    function automatic t_crc serial_step(input t_sel sel, input t_crc crc, input logic bit_in);
        logic fb;
        t_crc nx;
        fb = 1'b0;
        nx = crc;
        case (sel)
            POLY_CRC5: begin
                fb = crc[4] ^ bit_in;
                nx = {11'd0, crc[3:0], 1'b0};
                if (fb) nx = nx ^ 16'h0005;
            end
            POLY_CRC8: begin
                fb = crc[7] ^ bit_in;
                nx = {8'd0, crc[6:0], 1'b0};
                if (fb) nx = nx ^ 16'h0007;
            end
            POLY_C16_A: begin
                fb = crc[15] ^ bit_in;
                nx = {crc[14:0], 1'b0};
                if (fb) nx = nx ^ 16'h1021;
            end
            POLY_C16_B: begin
                fb = crc[15] ^ bit_in;
                nx = {crc[14:0], fb};
                if (crc[15]) nx = nx ^ 16'h1020;
            end
            POLY_C16_C: begin
                fb = crc[15] ^ bit_in;
                nx = {crc[14:0], 1'b0};
                if (fb) nx = nx ^ 16'h9021;
            end
            default: begin
                nx = crc;
            end
        endcase
        return nx;
    endfunction

endpackage

/* hw/rtl/multi_poly_crc_word_update.sv */
// ----------------------------------------------------------------------------
// multi_poly_crc_word_update
// Updates a running crc with one data word per request, msb first, over a
// selectable crc-5, crc-8 or crc-16 polynomial.
// ----------------------------------------------------------------------------
// path: accepted request into the input register, then the unrolled xor network
//   into the crc/result register, which also closes the crc update loop
// throughput: one request per cycle unless the output stalls
// reset: synchronous active-low; crc register cleared, poly_select = 2,
//   word_bits = 8, seed = 0, no result pending
module multi_poly_crc_word_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  mpcrc_pkg::t_cfg_idx  i_cfg_index,
    input  mpcrc_pkg::t_crc      i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mpcrc_pkg::t_data     i_data_word,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mpcrc_pkg::t_crc      o_crc_value
);
    import mpcrc_pkg::*;

    t_sel       r_poly;
    t_word_bits r_word_bits;
    t_crc       r_seed;

    logic  r_s1_valid;
    t_data r_data;
    logic  r_restart;

    logic  r_out_valid;
    t_crc  r_crc;
    t_crc  n_crc;

    logic       out_load;
    logic       in_accept;
    t_word_bits n_used;
    t_crc       mask;

    assign o_cfg_ready = 1'b1;

    assign out_load   = r_s1_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= POLY_RESET;
            r_word_bits <= WORD_BITS_RESET;
            r_seed      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POLY_SELECT: r_poly      <= i_cfg_data[SEL_W-1:0];
                CFG_WORD_BITS:   r_word_bits <= i_cfg_data[WORD_BITS_W-1:0];
                CFG_SEED:        r_seed      <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data    <= i_data_word;
            r_restart <= i_restart;
        end
    end

    // unrolled crc update
    assign n_used = (r_word_bits > WORD_BITS_MAX) ? WORD_BITS_MAX : r_word_bits;
    assign mask   = sel_known(r_poly) ? width_mask(r_poly) : 16'hFFFF;

    always_comb begin
        n_crc = r_restart ? (r_seed & mask) : r_crc;
        if (sel_known(r_poly)) begin
            n_crc = n_crc & mask;
            for (int i = MAX_WORD_BITS - 1; i >= 0; i--) begin
                if (WORD_BITS_W'(i) < n_used) begin
                    n_crc = serial_step(r_poly, n_crc, r_data[i]);
                end
            end
            n_crc = n_crc & mask;
        end
    end

    // crc state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_crc <= n_crc;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc;

    a_crc5_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_poly == POLY_CRC5) |-> (o_crc_value[15:5] == '0))
        else $error("crc5 result has bits above width");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked request");

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("pending request not moved to result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_crc_value == '0))
        else $error("result state not cleared by reset");

endmodule

/* tb/tb_multi_poly_crc_word_update.sv */
// ----------------------------------------------------------------------------
// tb_multi_poly_crc_word_update
// Self-checking bench for the multi-polynomial crc word update. A driver
// feeds data-word requests from a queue, a monitor checks each crc result
// against a bit-serial predictor kept in step with the config writes. Runs
// a directed set of corner cases, then random segments under several
// settings and back-pressure profiles, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_multi_poly_crc_word_update;
    import mpcrc_pkg::*;

    localparam int       QUIET_LIMIT  = 1000;
    localparam int       HOLD_CYCLES  = 60;
    localparam int       SEGMENTS     = 35;
    localparam int       SEGMENT_LEN  = 50;
    localparam t_cfg_idx CFG_UNUSED   = 2'd3;

    typedef struct packed {
        t_data data;
        logic  restart;
    } t_crc_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = '0;
    t_crc       i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_data      i_data_word = '0;
    logic       i_restart   = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_crc       o_crc_value;

    t_crc_word  pending_words[$];
    t_crc       expected_crcs[$];

    t_sel       model_sel       = POLY_RESET;
    t_word_bits model_word_bits = WORD_BITS_RESET;
    t_crc       model_seed      = '0;
    t_crc       model_crc       = '0;

    int         send_idle_pct  = 26;
    int         recv_idle_pct  = 57;
    int         words_accepted = 0;
    int         error_cnt      = 0;
    int         quiet_cycles   = 0;
    int         hold_left      = 0;
    int         next_hold_at   = 500;

    multi_poly_crc_word_update DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_word (i_data_word),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

    always #5 i_clk = ~i_clk;

    // bit-serial galois update, msb of the used bits first
    function automatic t_crc crc_after_word(input t_sel sel, input t_word_bits wb,
                                            input t_crc seed_v, input t_crc cur,
                                            input t_data data, input logic restart);
        t_crc mask;
        t_crc r;
        int   n;
        logic fb;
        logic top;
        mask = 16'hFFFF;
        if (sel == POLY_CRC5) mask = 16'h001F;
        else if (sel == POLY_CRC8) mask = 16'h00FF;
        n = (int'(wb) > MAX_WORD_BITS) ? MAX_WORD_BITS : int'(wb);
        r = cur;
        if (restart) r = seed_v & mask;
        if (sel <= POLY_C16_C) begin
            r = r & mask;
            for (int i = n - 1; i >= 0; i--) begin
                top = r[15];
                case (sel)
                    POLY_CRC5: begin
                        fb = r[4] ^ data[i];
                        r = {r[14:0], 1'b0} & 16'h001F;
                        if (fb) r = r ^ 16'h0005;
                    end
                    POLY_CRC8: begin
                        fb = r[7] ^ data[i];
                        r = {r[14:0], 1'b0} & 16'h00FF;
                        if (fb) r = r ^ 16'h0007;
                    end
                    POLY_C16_A: begin
                        fb = top ^ data[i];
                        r = {r[14:0], 1'b0};
                        if (fb) r = r ^ 16'h1021;
                    end
                    POLY_C16_B: begin
                        fb = top ^ data[i];
                        r = {r[14:0], fb};
                        if (top) r = r ^ 16'h1020;
                    end
                    default: begin
                        fb = top ^ data[i];
                        r = {r[14:0], 1'b0};
                        if (fb) r = r ^ 16'h9021;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                model_crc = crc_after_word(model_sel, model_word_bits, model_seed,
                                           model_crc, i_data_word, i_restart);
                expected_crcs.push_back(model_crc);
                words_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_data_word <= pending_words[0].data;
                    i_restart   <= pending_words[0].restart;
                    void'(pending_words.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output back-pressure, with occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (words_accepted >= next_hold_at && pending_words.size() > 8) begin
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 900;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_crc want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_crcs.size() == 0) begin
                $display("%0t crc result with none expected: expected none, actual %h",
                         $time, o_crc_value);
                error_cnt++;
            end else begin
                want = expected_crcs.pop_front();
                if (o_crc_value !== want) begin
                    $display("%0t crc_value mismatch: expected %h, actual %h",
                             $time, want, o_crc_value);
                    error_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input t_crc value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POLY_SELECT: model_sel       = value[SEL_W-1:0];
            CFG_WORD_BITS:   model_word_bits = value[WORD_BITS_W-1:0];
            CFG_SEED:        model_seed      = value;
            default:         ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || expected_crcs.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic push_word(input t_data data, input logic restart);
        t_crc_word w;
        w.data    = data;
        w.restart = restart;
        pending_words.push_back(w);
    endtask

    task automatic directed_word(input t_sel sel, input t_word_bits wb, input t_crc seed_v,
                                 input t_data data, input logic restart);
        write_reg(CFG_POLY_SELECT, t_crc'(sel));
        write_reg(CFG_WORD_BITS, t_crc'(wb));
        write_reg(CFG_SEED, seed_v);
        push_word(data, restart);
        wait_idle();
    endtask

    task automatic random_segment(input int count);
        t_sel       sel;
        t_word_bits wb;
        int         pick;
        pick = $urandom_range(99);
        sel = (pick < 90) ? t_sel'($urandom_range(4)) : t_sel'($urandom_range(7, 5));
        pick = $urandom_range(99);
        if (pick < 80) wb = t_word_bits'($urandom_range(32, 1));
        else if (pick < 88) wb = '0;
        else wb = t_word_bits'($urandom_range(63, 33));
        if ($urandom_range(9) < 7) write_reg(CFG_POLY_SELECT, {13'($urandom), sel});
        if ($urandom_range(9) < 7) write_reg(CFG_WORD_BITS, {10'($urandom), wb});
        if ($urandom_range(9) < 7) write_reg(CFG_SEED, t_crc'($urandom));
        for (int k = 0; k < count; k++) begin
            if (k == 0) push_word($urandom, $urandom_range(9) != 0);
            else push_word($urandom, $urandom_range(99) < 10);
        end
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, no writes yet
        push_word(32'h0000_00A5, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        wait_idle();

        directed_word(POLY_CRC5, 6'd32, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        directed_word(POLY_CRC5, 6'd32, 16'hFFFF, 32'h0000_0000, 1'b0);
        directed_word(POLY_CRC8, 6'd32, 16'hFFFF, 32'h8000_0001, 1'b1);
        directed_word(POLY_C16_A, 6'd32, 16'hFFFF, 32'h1234_5678, 1'b1);
        directed_word(POLY_C16_B, 6'd32, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        directed_word(POLY_C16_B, 6'd16, 16'h8000, 32'h0000_0000, 1'b1);
        directed_word(POLY_C16_C, 6'd32, 16'hFFFF, 32'h0000_0000, 1'b1);
        directed_word(POLY_C16_C, 6'd1, 16'h0000, 32'h0000_0001, 1'b0);
        // narrow polynomial picked up without restart
        directed_word(POLY_CRC5, 6'd5, 16'h0000, 32'h0000_001F, 1'b0);
        // unknown selectors
        directed_word(3'd5, 6'd8, 16'hABCD, 32'h0000_00FF, 1'b1);
        directed_word(3'd6, 6'd8, 16'h0000, 32'h0000_00FF, 1'b0);
        directed_word(3'd7, 6'd32, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        // zero word length
        directed_word(POLY_C16_A, 6'd0, 16'h1234, 32'hFFFF_FFFF, 1'b1);
        directed_word(POLY_C16_A, 6'd0, 16'h1234, 32'hFFFF_FFFF, 1'b0);
        // word length above the maximum saturates
        directed_word(POLY_CRC8, 6'd63, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        directed_word(POLY_C16_A, 6'd33, 16'h0000, 32'h8000_0000, 1'b0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        directed_word(POLY_C16_A, 6'd8, 16'h0000, 32'h0000_00C3, 1'b0);
        directed_word(POLY_CRC5, 6'd1, 16'h001F, 32'h0000_0000, 1'b1);

        for (int s = 0; s < SEGMENTS; s++) begin
            if (s == SEGMENTS / 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 26;
            end else if (s == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_segment(SEGMENT_LEN);
        end

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (error_cnt == 0 && expected_crcs.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* multi_poly_crc_word_update.f */
hw/rtl/mpcrc_pkg.sv
hw/rtl/multi_poly_crc_word_update.sv
tb/tb_multi_poly_crc_word_update.sv
